FILE: rtl/ctg_pkg.sv
// ctg_pkg: constants, register codes, pipeline stage map and rounding helpers
// for the circular trajectory generator. No dependencies.
`timescale 1ns / 1ps

package ctg_pkg;

    // CORDIC depth, capped at the size of the arctangent table
    localparam int TRIG_STAGES = 16;
    localparam int CORDIC_MAX  = 24;
    localparam int NCORD       = (TRIG_STAGES > CORDIC_MAX) ? CORDIC_MAX : TRIG_STAGES;

    // CORDIC datapath width (Q2.30 values plus growth and sign)
    localparam int CW = 34;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;

    // Pipeline stage map (index into the valid vector)
    localparam int S_MAG  = 0;               // |time - start|, sign
    localparam int S_FRAC = 1;               // fractional turn, 48 bit
    localparam int S_TURN = 2;               // quadrant and residual turn
    localparam int S_ANG  = 3;               // residual angle, Q2.30
    localparam int S_CRD0 = 4;               // first CORDIC iteration
    localparam int S_TRIG = S_CRD0 + NCORD;  // cos/sin in Q1.15
    localparam int S_AB   = S_TRIG + 1;      // radius products
    localparam int S_PROD = S_AB + 1;        // tilt products
    localparam int S_OUT  = S_PROD + 1;      // rounded, saturated word
    localparam int NSTAGE = S_OUT + 1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_T_ORIGIN   = 3'd0,
        REG_RADIUS     = 3'd1,
        REG_BOARD_COS  = 3'd2,
        REG_BOARD_SIN  = 3'd3,
        REG_OFFSET_X   = 3'd4,
        REG_OFFSET_Y   = 3'd5,
        REG_OFFSET_Z   = 3'd6,
        REG_TIP_PITCH  = 3'd7
    } cfg_reg_t;

    // atan(2^-i) in Q2.30
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] r;
        case (idx)
            5'd0:    r = 34'sd843314857;
            5'd1:    r = 34'sd497837829;
            5'd2:    r = 34'sd263043837;
            5'd3:    r = 34'sd133525159;
            5'd4:    r = 34'sd67021687;
            5'd5:    r = 34'sd33543516;
            5'd6:    r = 34'sd16775851;
            5'd7:    r = 34'sd8388437;
            5'd8:    r = 34'sd4194283;
            5'd9:    r = 34'sd2097149;
            5'd10:   r = 34'sd1048576;
            5'd11:   r = 34'sd524288;
            5'd12:   r = 34'sd262144;
            5'd13:   r = 34'sd131072;
            5'd14:   r = 34'sd65536;
            5'd15:   r = 34'sd32768;
            5'd16:   r = 34'sd16384;
            5'd17:   r = 34'sd8192;
            5'd18:   r = 34'sd4096;
            5'd19:   r = 34'sd2048;
            5'd20:   r = 34'sd1024;
            5'd21:   r = 34'sd512;
            5'd22:   r = 34'sd256;
            5'd23:   r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Q2.30 to Q1.15: round half up, saturate
    function automatic logic signed [15:0] rnd_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = (v + 34'sd16384) >>> 15;
        if (t > 34'sd32767)
            return 16'sh7FFF;
        else if (t < -34'sd32768)
            return 16'sh8000;
        else
            return t[15:0];
    endfunction

    // Q3.45 product to Q3.13, optional negation first
    function automatic logic signed [17:0] rnd_tilt(input logic signed [47:0] p,
                                                   input logic neg);
        logic signed [48:0] e;
        logic signed [48:0] sh;
        e = {p[47], p};
        if (neg)
            e = -e;
        e  = e + 49'sd2147483648;
        sh = e >>> 32;
        return sh[17:0];
    endfunction

    // Q2.30 to Q3.13, optional negation first
    function automatic logic signed [17:0] rnd_flat(input logic signed [31:0] v,
                                                   input logic neg);
        logic signed [32:0] e;
        logic signed [32:0] sh;
        e = {v[31], v};
        if (neg)
            e = -e;
        e  = e + 33'sd65536;
        sh = e >>> 17;
        return sh[17:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767)
            return 16'sh7FFF;
        else if (v < -18'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage

FILE: rtl/circular_trajectory_generator_top.sv
// circular_trajectory_generator_top: time stamp in, circle reference sample out
// (position, velocity, acceleration, pitch). Depends on ctg_pkg.
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Word
// in       input      in_valid / in_stall   time_now (Q16.16 s)
// out      output     out_valid / out_stall pos, vel, acc xyz, pitch_out (Q3.13)
// cfg      input      cfg_we                cfg_index, cfg_data
//
// One word accepted per cycle unless every stage is full and the output is
// stalled; the depth is set by the one-iteration-per-stage CORDIC pipeline.
// Reset clears the stage valid bits and loads the register defaults.
// A stalled output freezes only the run of full stages next to it; other stages
// keep filling, so the input is stalled only when every stage holds a word.
module circular_trajectory_generator_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         time_now,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  pos_x,
    output logic signed [15:0]  pos_y,
    output logic signed [15:0]  pos_z,
    output logic signed [15:0]  vel_x,
    output logic signed [15:0]  vel_y,
    output logic signed [15:0]  vel_z,
    output logic signed [15:0]  acc_x,
    output logic signed [15:0]  acc_y,
    output logic signed [15:0]  acc_z,
    output logic signed [15:0]  pitch_out,
    input  logic                cfg_we,
    input  ctg_pkg::cfg_reg_t   cfg_index,
    input  logic [31:0]         cfg_data
);
    import ctg_pkg::*;

    // Configuration registers
    logic [31:0]        t_origin_reg;
    logic [14:0]        radius_reg;
    logic signed [15:0] board_cos_reg;
    logic signed [15:0] board_sin_reg;
    logic signed [15:0] offset_x_reg;
    logic signed [15:0] offset_y_reg;
    logic signed [15:0] offset_z_reg;
    logic signed [15:0] tip_pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_origin_reg   <= '0;
            radius_reg     <= 15'd4915;
            board_cos_reg  <= 16'sd32767;
            board_sin_reg  <= '0;
            offset_x_reg   <= -16'sd4506;
            offset_y_reg   <= '0;
            offset_z_reg   <= 16'sd4096;
            tip_pitch_reg  <= -16'sd25736;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_T_ORIGIN:   t_origin_reg   <= cfg_data;
                REG_RADIUS:     radius_reg     <= cfg_data[14:0];
                REG_BOARD_COS:  board_cos_reg  <= cfg_data[15:0];
                REG_BOARD_SIN:  board_sin_reg  <= cfg_data[15:0];
                REG_OFFSET_X:   offset_x_reg   <= cfg_data[15:0];
                REG_OFFSET_Y:   offset_y_reg   <= cfg_data[15:0];
                REG_OFFSET_Z:   offset_z_reg   <= cfg_data[15:0];
                REG_TIP_PITCH:  tip_pitch_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Stage valid bits and per-stage load enables.
    // A stage loads when it is empty or when every stage after it can move.
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] v_next;
    logic [NSTAGE-1:0] en;

    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_en
        assign en[k] = !out_stall || !(&v_reg[NSTAGE-1:k]);
    end

    assign v_next   = {v_reg[NSTAGE-2:0], in_valid};
    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= (v_next & en) | (v_reg & ~en);
    end

    // Phase: magnitude and sign of time_now - t_origin
    logic [32:0] diff;
    logic [31:0] mag_reg;
    logic        neg1_reg;

    assign diff = {1'b0, time_now} - {1'b0, t_origin_reg};

    always_ff @(posedge clk)
    begin
        if (en[S_MAG])
        begin
            mag_reg  <= diff[32] ? (32'd0 - diff[31:0]) : diff[31:0];
            neg1_reg <= diff[32];
        end
    end

    // Turns: |d| / 2pi, fractional part in 48 bits
    logic [61:0] turn_prod;
    logic [47:0] frac_reg;
    logic        neg2_reg;

    assign turn_prod = mag_reg * INV_TWO_PI_Q32;

    always_ff @(posedge clk)
    begin
        if (en[S_FRAC])
        begin
            frac_reg <= turn_prod[47:0];
            neg2_reg <= neg1_reg;
        end
    end

    // Negative time runs the turn backwards; split quadrant and residual
    logic [47:0] frac_signed;
    logic [1:0]  quad3_reg;
    logic [29:0] resid_reg;

    assign frac_signed = neg2_reg ? (48'd0 - frac_reg) : frac_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_TURN])
        begin
            quad3_reg <= frac_signed[47:46];
            resid_reg <= frac_signed[45:16];
        end
    end

    // Residual turn to radians, Q2.30
    logic [60:0]          ang_prod;
    logic signed [CW-1:0] ang_reg;
    logic [1:0]           quad4_reg;

    assign ang_prod = resid_reg * HALF_PI_Q30;

    always_ff @(posedge clk)
    begin
        if (en[S_ANG])
        begin
            ang_reg   <= {3'b000, ang_prod[60:30]};
            quad4_reg <= quad3_reg;
        end
    end

    // CORDIC rotation, one iteration per stage
    logic signed [CW-1:0] xs [NCORD];
    logic signed [CW-1:0] ys [NCORD];
    logic signed [CW-1:0] zs [NCORD];
    logic [1:0]           qs [NCORD];
    logic signed [CW-1:0] cx_reg [NCORD];
    logic signed [CW-1:0] cy_reg [NCORD];
    logic signed [CW-1:0] cz_reg [NCORD];
    logic [1:0]           cq_reg [NCORD];

    assign xs[0] = CORDIC_GAIN;
    assign ys[0] = '0;
    assign zs[0] = ang_reg;
    assign qs[0] = quad4_reg;

    for (genvar i = 0; i < NCORD; i++)
    begin : g_cordic
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        if (i > 0)
        begin : g_link
            assign xs[i] = cx_reg[i-1];
            assign ys[i] = cy_reg[i-1];
            assign zs[i] = cz_reg[i-1];
            assign qs[i] = cq_reg[i-1];
        end

        assign dx = ys[i] >>> i;
        assign dy = xs[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en[S_CRD0 + i])
            begin
                // rotate toward zero residual angle
                if (!zs[i][CW-1])
                begin
                    cx_reg[i] <= xs[i] - dx;
                    cy_reg[i] <= ys[i] + dy;
                    cz_reg[i] <= zs[i] - atan_q30(5'(i));
                end
                else
                begin
                    cx_reg[i] <= xs[i] + dx;
                    cy_reg[i] <= ys[i] - dy;
                    cz_reg[i] <= zs[i] + atan_q30(5'(i));
                end
                cq_reg[i] <= qs[i];
            end
        end
    end

    // Quadrant fold, round to Q1.15
    logic signed [CW-1:0] cos_full;
    logic signed [CW-1:0] sin_full;
    logic signed [15:0]   co_reg;
    logic signed [15:0]   si_reg;

    always_comb
    begin
        case (cq_reg[NCORD-1])
            2'd0:
            begin
                cos_full = cx_reg[NCORD-1];
                sin_full = cy_reg[NCORD-1];
            end
            2'd1:
            begin
                cos_full = -cy_reg[NCORD-1];
                sin_full = cx_reg[NCORD-1];
            end
            2'd2:
            begin
                cos_full = -cx_reg[NCORD-1];
                sin_full = -cy_reg[NCORD-1];
            end
            default:
            begin
                cos_full = cy_reg[NCORD-1];
                sin_full = -cx_reg[NCORD-1];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[S_TRIG])
        begin
            co_reg <= rnd_q15(cos_full);
            si_reg <= rnd_q15(sin_full);
        end
    end

    // a = r cos, b = r sin (Q2.30)
    logic signed [15:0] radius_s;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;

    assign radius_s = {1'b0, radius_reg};

    always_ff @(posedge clk)
    begin
        if (en[S_AB])
        begin
            a_reg <= radius_s * co_reg;
            b_reg <= radius_s * si_reg;
        end
    end

    // Tilt products (Q3.45)
    logic signed [47:0] pca_reg;
    logic signed [47:0] psa_reg;
    logic signed [47:0] pcb_reg;
    logic signed [47:0] psb_reg;
    logic signed [31:0] a2_reg;
    logic signed [31:0] b2_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_PROD])
        begin
            pca_reg <= board_cos_reg * a_reg;
            psa_reg <= board_sin_reg * a_reg;
            pcb_reg <= board_cos_reg * b_reg;
            psb_reg <= board_sin_reg * b_reg;
            a2_reg  <= a_reg;
            b2_reg  <= b_reg;
        end
    end

    // Round to Q3.13, add offsets to position, saturate
    logic signed [15:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [15:0] vel_x_reg, vel_y_reg, vel_z_reg;
    logic signed [15:0] acc_x_reg, acc_y_reg, acc_z_reg;
    logic signed [15:0] pitch_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            pos_x_reg <= sat16(rnd_tilt(pca_reg, 1'b0) + 18'(offset_x_reg));
            pos_y_reg <= sat16(rnd_flat(b2_reg, 1'b0) + 18'(offset_y_reg));
            pos_z_reg <= sat16(rnd_tilt(psa_reg, 1'b1) + 18'(offset_z_reg));
            vel_x_reg <= sat16(rnd_tilt(pcb_reg, 1'b1));
            vel_y_reg <= sat16(rnd_flat(a2_reg, 1'b0));
            vel_z_reg <= sat16(rnd_tilt(psb_reg, 1'b0));
            acc_x_reg <= sat16(rnd_tilt(pca_reg, 1'b1));
            acc_y_reg <= sat16(rnd_flat(b2_reg, 1'b1));
            acc_z_reg <= sat16(rnd_tilt(psa_reg, 1'b0));
            pitch_reg <= tip_pitch_reg;
        end
    end

    assign out_valid = v_reg[NSTAGE-1];
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;
    assign vel_z     = vel_z_reg;
    assign acc_x     = acc_x_reg;
    assign acc_y     = acc_y_reg;
    assign acc_z     = acc_z_reg;
    assign pitch_out = pitch_reg;

    // Input backs up only when the whole pipeline is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && (&v_reg)))
        else $error("input stalled while pipeline has room");

    // An accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v_reg[S_MAG])
        else $error("accepted word lost at pipeline entry");

    // Delivering a word with no new input drops the occupancy by exactly one
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !in_valid) |=>
        ($countones(v_reg) == $past($countones(v_reg)) - 1))
        else $error("pipeline occupancy mismatch");

endmodule

FILE: tb/sv/ctg_tb_pkg.sv
// ctg_tb_pkg: sample type and the checker class that predicts and compares
// circle reference samples. Depends on ctg_pkg for register codes and TRIG_STAGES.
`timescale 1ns / 1ps

package ctg_tb_pkg;

    localparam int SAMPLE_FIELDS = 10;

    // CORDIC depth as built, capped at the arctangent table size
    localparam int ROTATIONS = (ctg_pkg::TRIG_STAGES > 24) ? 24 : ctg_pkg::TRIG_STAGES;

    localparam longint ROT_GAIN_Q30      = 652032874;
    localparam longint TURNS_PER_RAD_Q32 = 683565276;
    localparam longint QUARTER_TURN_Q30  = 1686629713;

    // atan(2^-n) in Q2.30
    localparam longint ATAN_Q30 [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_t;

    // One output word, first field in the top bits
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
        logic signed [15:0] pitch_out;
    } traj_sample_t;

    class circle_sample_checker;

        // register image, same reset values as the block
        logic [31:0]        t_origin;
        logic [14:0]        radius;
        logic signed [15:0] board_cos;
        logic signed [15:0] board_sin;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_z;
        logic signed [15:0] tip_pitch;

        traj_sample_t expected_samples[$];
        int           mismatches;
        int           samples_seen;

        function new();
            t_origin     = '0;
            radius       = 15'd4915;
            board_cos    = 16'sd32767;
            board_sin    = '0;
            offset_x     = -16'sd4506;
            offset_y     = '0;
            offset_z     = 16'sd4096;
            tip_pitch    = -16'sd25736;
            mismatches   = 0;
            samples_seen = 0;
        endfunction

        // mirror a register write; upper data bits are dropped as in hardware
        function void set_register(ctg_pkg::cfg_reg_t idx, logic [31:0] data);
            case (idx)
                ctg_pkg::REG_T_ORIGIN:   t_origin   = data;
                ctg_pkg::REG_RADIUS:     radius     = data[14:0];
                ctg_pkg::REG_BOARD_COS:  board_cos  = data[15:0];
                ctg_pkg::REG_BOARD_SIN:  board_sin  = data[15:0];
                ctg_pkg::REG_OFFSET_X:   offset_x   = data[15:0];
                ctg_pkg::REG_OFFSET_Y:   offset_y   = data[15:0];
                ctg_pkg::REG_OFFSET_Z:   offset_z   = data[15:0];
                ctg_pkg::REG_TIP_PITCH:  tip_pitch  = data[15:0];
                default: ;
            endcase
        endfunction

        function logic signed [15:0] clamp16(longint v);
            if (v > 32767)
                return 16'sh7FFF;
            if (v < -32768)
                return 16'sh8000;
            return v[15:0];
        endfunction

        // Q1.15 tilt times Q2.30 value, rounded to Q3.13
        function longint tilt_q13(longint k, longint v);
            return (k * v + (longint'(1) << 31)) >>> 32;
        endfunction

        // Q2.30 value rounded to Q3.13
        function longint flat_q13(longint v);
            return (v + 65536) >>> 17;
        endfunction

        function traj_sample_t circle_sample(logic [31:0] t);
            logic         behind;
            logic [31:0]  span;
            logic [63:0]  turns;
            logic [47:0]  frac;
            logic [31:0]  turn;
            quadrant_t    quad;
            longint       x, y, z, dx, dy, cs, sn, co, si, a, b, bc, bs;
            traj_sample_t s;

            // phase as a fraction of a turn; runs backwards before start
            behind = t < t_origin;
            span   = behind ? t_origin - t : t - t_origin;
            turns  = 64'(span) * 64'(TURNS_PER_RAD_Q32);
            frac   = turns[47:0];
            if (behind)
                frac = 48'd0 - frac;
            turn = frac[47:16];
            quad = quadrant_t'(turn[31:30]);
            z    = longint'((64'(turn[29:0]) * 64'(QUARTER_TURN_Q30)) >> 30);

            // rotation-mode CORDIC on the residual angle
            x = ROT_GAIN_Q30;
            y = 0;
            for (int n = 0; n < ROTATIONS; n++)
            begin
                dx = y >>> n;
                dy = x >>> n;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_Q30[n];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_Q30[n];
                end
            end

            // quadrant rotation by multiples of pi/2
            case (quad)
                QUAD_I:   begin cs = x;  sn = y;  end
                QUAD_II:  begin cs = -y; sn = x;  end
                QUAD_III: begin cs = -x; sn = -y; end
                default:  begin cs = y;  sn = -x; end
            endcase
            co = clamp16((cs + 16384) >>> 15);
            si = clamp16((sn + 16384) >>> 15);

            a  = longint'(radius) * co;
            b  = longint'(radius) * si;
            bc = longint'(board_cos);
            bs = longint'(board_sin);

            s.pos_x     = clamp16(tilt_q13(bc, a) + longint'(offset_x));
            s.pos_y     = clamp16(flat_q13(b) + longint'(offset_y));
            s.pos_z     = clamp16(tilt_q13(-bs, a) + longint'(offset_z));
            s.vel_x     = clamp16(tilt_q13(-bc, b));
            s.vel_y     = clamp16(flat_q13(a));
            s.vel_z     = clamp16(tilt_q13(bs, b));
            s.acc_x     = clamp16(tilt_q13(-bc, a));
            s.acc_y     = clamp16(flat_q13(-b));
            s.acc_z     = clamp16(tilt_q13(bs, a));
            s.pitch_out = tip_pitch;
            return s;
        endfunction

        function string field_name(int k);
            case (k)
                0:       return "pos_x";
                1:       return "pos_y";
                2:       return "pos_z";
                3:       return "vel_x";
                4:       return "vel_y";
                5:       return "vel_z";
                6:       return "acc_x";
                7:       return "acc_y";
                8:       return "acc_z";
                default: return "pitch_out";
            endcase
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        // accepted input word: queue its expected sample
        function void note_time(logic [31:0] t);
            expected_samples.push_back(circle_sample(t));
        endfunction

        // accepted output word: compare against the oldest expectation
        task check_sample(traj_sample_t got);
            traj_sample_t                want;
            logic [16*SAMPLE_FIELDS-1:0] got_bits;
            logic [16*SAMPLE_FIELDS-1:0] want_bits;
            logic signed [15:0]          g;
            logic signed [15:0]          w;

            if (expected_samples.size() == 0)
            begin
                report_mismatch($sformatf("sample with none pending, pos_x %0d", got.pos_x));
                return;
            end
            want      = expected_samples.pop_front();
            got_bits  = got;
            want_bits = want;
            for (int k = 0; k < SAMPLE_FIELDS; k++)
            begin
                g = got_bits[16*(SAMPLE_FIELDS-k)-1 -: 16];
                w = want_bits[16*(SAMPLE_FIELDS-k)-1 -: 16];
                if (g !== w)
                    report_mismatch($sformatf("sample %0d %s: got %0d, expected %0d",
                                              samples_seen, field_name(k), g, w));
            end
            samples_seen++;
        endtask

    endclass

endpackage

FILE: tb/sv/tb_top.sv
// tb_top: drives time stamps and register writes into the circular trajectory
// generator and checks every output word. Depends on ctg_pkg and ctg_tb_pkg.
`timescale 1ns / 1ps

module tb_top;

    import ctg_pkg::*;
    import ctg_tb_pkg::*;

    localparam int LATENCY         = TRIG_STAGES + 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 144;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum {SET_RANDOM, SET_LOW, SET_HIGH} setting_style_t;

    // start at zero: on time, at quarter turns, at a full turn, far out
    localparam logic [31:0] PLAIN_TIMES [10] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0001_921F, 32'h0003_243F, 32'h0004_B65F,
        32'h0006_487F, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_AAAA, 32'hFFFF_FFFF
    };
    // start at mid range: times behind and ahead of it, wrap at both ends
    localparam logic [31:0] SKEWED_TIMES [8] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h8000_0001, 32'h7FFE_6DE1, 32'h1234_5678, 32'hAAAA_5555
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [31:0]        time_now = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] pos_x, pos_y, pos_z;
    logic signed [15:0] vel_x, vel_y, vel_z;
    logic signed [15:0] acc_x, acc_y, acc_z;
    logic signed [15:0] pitch_out;
    logic               cfg_we = 1'b0;
    cfg_reg_t           cfg_index = REG_T_ORIGIN;
    logic [31:0]        cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_cnt = 0;

    circle_sample_checker sb = new();

    circular_trajectory_generator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .time_now  (time_now),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_z     (vel_z),
        .acc_x     (acc_x),
        .acc_y     (acc_y),
        .acc_z     (acc_z),
        .pitch_out (pitch_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // output monitor
    always @(posedge clk)
    begin : watch_out
        traj_sample_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.pos_x     = pos_x;
            got.pos_y     = pos_y;
            got.pos_z     = pos_z;
            got.vel_x     = vel_x;
            got.vel_y     = vel_y;
            got.vel_z     = vel_z;
            got.acc_x     = acc_x;
            got.acc_y     = acc_y;
            got.acc_z     = acc_z;
            got.pitch_out = pitch_out;
            sb.check_sample(got);
        end
    end

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 70; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            IDLE_BOTH:     begin send_idle_pct = 31; recv_stall_pct = 31; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // one time stamp; valid stays high into the next call unless it idles
    task automatic send_time(logic [31:0] t);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        time_now <= t;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_time(t);
    endtask

    task automatic load_register(cfg_reg_t idx, logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // drop valid, let every expected word come out, then the pipeline depth
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_samples.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // register value: random, or an extreme; upper bits carry junk
    function automatic logic [31:0] setting_value(cfg_reg_t idx, setting_style_t style);
        logic [31:0] v;
        logic        hi;
        v = $urandom;
        if (style == SET_RANDOM && $urandom_range(3) != 0)
            return v;
        hi = (style == SET_HIGH) || (style == SET_RANDOM && $urandom_range(1) == 1);
        case (idx)
            REG_T_ORIGIN:   v = hi ? 32'hFFFF_FFFF : 32'h0000_0000;
            REG_RADIUS:     v[14:0] = hi ? 15'h7FFF : 15'h0000;
            default:        v[15:0] = hi ? 16'h7FFF : 16'h8000;
        endcase
        return v;
    endfunction

    task automatic load_setting(setting_style_t style);
        cfg_reg_t idx;
        idx = idx.first();
        do
        begin
            load_register(idx, setting_value(idx, style));
            idx = idx.next();
        end
        while (idx != idx.first());
    endtask

    // random time: anywhere, around the origin time, small, or just behind the origin
    function automatic logic [31:0] pick_time();
        case ($urandom_range(4))
            0, 1:    return $urandom;
            2:       return sb.t_origin + $urandom_range(32'h0003_FFFF) - 32'h0002_0000;
            3:       return $urandom_range(32'h000F_FFFF);
            default: return sb.t_origin - $urandom_range(32'h000F_FFFF);
        endcase
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings
        set_idle(IDLE_NONE);
        foreach (PLAIN_TIMES[i])
            send_time(PLAIN_TIMES[i]);
        settle();

        // directed: start mid range, full radius, tilt pair not on the unit
        // circle, offsets at the rails so position saturates
        load_register(REG_T_ORIGIN,   32'h8000_0000);
        load_register(REG_RADIUS,     32'h0000_7FFF);
        load_register(REG_BOARD_COS,  32'h0000_8000);
        load_register(REG_BOARD_SIN,  32'hFFFF_8000);
        load_register(REG_OFFSET_X,   32'h0000_7FFF);
        load_register(REG_OFFSET_Y,   32'h0000_8000);
        load_register(REG_OFFSET_Z,   32'h0000_7FFF);
        load_register(REG_TIP_PITCH,  32'h0000_7FFF);
        foreach (SKEWED_TIMES[i])
            send_time(SKEWED_TIMES[i]);

        // random phases: low and high extremes first, then random settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            if (phase == 0)
                load_setting(SET_LOW);
            else if (phase == 1)
                load_setting(SET_HIGH);
            else
                load_setting(SET_RANDOM);
            set_idle(idle_mode_t'(phase % 4));
            repeat (WORDS_PER_PHASE) send_time(pick_time());
        end
        settle();

        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: circular_trajectory_generator_top.f
rtl/ctg_pkg.sv
rtl/circular_trajectory_generator_top.sv
tb/sv/ctg_tb_pkg.sv
tb/sv/tb_top.sv
